>>> design/minmod_slope_face_reconstruction_macros.svh
// Assertion macros for the minmod slope face reconstruction checker.
// Expects clk and rst_n in the scope of use.
`ifndef MINMOD_SLOPE_FACE_RECONSTRUCTION_MACROS_SVH
`define MINMOD_SLOPE_FACE_RECONSTRUCTION_MACROS_SVH

// same-cycle implication
`define MMSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mmsfr_pkg.sv
// Shared constants for the minmod slope face reconstruction block.
// No dependencies.
package mmsfr_pkg;

  localparam int CFG_W  = 4;  // var_count register width
  localparam int VIDX_W = 3;  // var_index field width
  localparam int CNT_W  = 5;  // holds a variable count of up to 16

endpackage

>>> design/mmsfr_in_if.sv
// Input channel: one cell variable per transaction.
// Depends on nothing.
interface mmsfr_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] cell_value;
  logic                         last_cell;

  modport source (output valid, cell_value, last_cell, input ready);
  modport sink   (input valid, cell_value, last_cell, output ready);
endinterface

>>> design/mmsfr_out_if.sv
// Result channel: limited slope and face values per transaction.
// Depends on mmsfr_pkg.
interface mmsfr_out_if #(parameter int DATA_WIDTH = 32);
  import mmsfr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] slope;
  logic signed [DATA_WIDTH-1:0] left_face;
  logic signed [DATA_WIDTH-1:0] right_face;
  logic [VIDX_W-1:0]            var_index;
  logic                         end_of_row;

  modport source (output valid, slope, left_face, right_face, var_index, end_of_row,
                  input ready);
  modport sink   (input valid, slope, left_face, right_face, var_index, end_of_row,
                  output ready);
endinterface

>>> design/mmsfr_cell.sv
// History cell for one variable: newer and older cell values.
// Read data passes down the chain from the neighbouring cell.
module mmsfr_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_W      = 3,
  parameter int IDX        = 0
) (
  input  logic                    clk,
  input  logic [POS_W-1:0]        addr,
  input  logic                    we,
  input  logic [DATA_WIDTH-1:0]   wr_data,
  input  logic [2*DATA_WIDTH-1:0] rd_in,
  output logic [2*DATA_WIDTH-1:0] rd_out
);

  logic                  hit;
  logic [DATA_WIDTH-1:0] newer_r;
  logic [DATA_WIDTH-1:0] older_r;

  assign hit    = (addr == POS_W'(IDX));
  assign rd_out = hit ? {newer_r, older_r} : rd_in;

  always_ff @(posedge clk) begin
    if (we && hit) begin
      older_r <= newer_r;
      newer_r <= wr_data;
    end
  end

endmodule

>>> design/minmod_slope_face_reconstruction.sv
// A result passes through stages s1 to s4 and the output register before it is valid.
// One input transaction is accepted per cycle while in_chan.ready is high; a final-cell
// transaction can hold the output register for two results, which backs up the pipe.
// Per-variable history lives in a chain of cells read in the accept cycle.
// Synchronous active-low reset clears pipe valids, position, cell count and
// sets var_count to 1; the history cells are not reset.
module minmod_slope_face_reconstruction #(
  parameter int MAX_VARS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mmsfr_in_if.sink                     in_chan,
  mmsfr_out_if.source                  out_chan,
  input  logic                         cfg_we,
  input  logic [mmsfr_pkg::CFG_W-1:0]  cfg_data
);
  import mmsfr_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int POS_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW:0]          HALF_RANGE = {2'b01, {(DW-1){1'b0}}};

  typedef struct packed {
    logic              emit;
    logic              slope_on;
    logic              last;
    logic              eor;
    logic [VIDX_W-1:0] vidx;
  } tag_t;

  function automatic logic signed [DW-1:0] sat_w(input logic signed [DW:0] x);
    logic signed [DW-1:0] r;
    if (x[DW] != x[DW-1]) r = x[DW] ? DMIN : DMAX;
    else                  r = x[DW-1:0];
    return r;
  endfunction

  // control
  logic [CFG_W-1:0] var_count_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       seen_r, seen_nxt;
  logic [CNT_W-1:0] vc_ext, count, pos_ext, p_ext;
  logic [POS_W-1:0] p;
  logic             cell_end, accept;
  tag_t             tag_in;

  // history chain
  logic [2*DW-1:0]  rd_bus [MAX_VARS+1];

  // pipe
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, o_a_r, o_b_r;
  logic s1_go, s2_go, s3_go, s4_go, o_adv;
  logic signed [DW-1:0] s1_prev_r, s1_old_r, s1_val_r;
  tag_t                 s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic signed [DW:0]   s2_dl_r, s2_dr_r;
  logic signed [DW-1:0] s2_prev_r, s2_val_r;
  logic [DW:0]          s3_mag_r, al, ar;
  logic                 s3_neg_r, s3_zero_r;
  logic signed [DW-1:0] s3_prev_r, s3_val_r;
  logic signed [DW-1:0] s4_slope_r, s4_prev_r, s4_val_r, slope_c, half_c;
  logic signed [DW-1:0] o_slope_r, o_lf_r, o_rf_r, o_val_r;
  logic [VIDX_W-1:0]    o_vidx_r;
  logic                 o_eor_r;

  always_comb begin
    vc_ext = CNT_W'(var_count_r);
    if (vc_ext == '0)                     count = CNT_W'(1);
    else if (vc_ext > CNT_W'(MAX_VARS))   count = CNT_W'(MAX_VARS);
    else                                  count = vc_ext;
    pos_ext  = CNT_W'(pos_r);
    p_ext    = (pos_ext >= count) ? count - CNT_W'(1) : pos_ext;
    p        = p_ext[POS_W-1:0];
    cell_end = ((p_ext + CNT_W'(1)) >= count);
  end

  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    tag_in.emit     = (seen_r != 2'd0);
    tag_in.slope_on = (seen_r == 2'd2);
    tag_in.last     = in_chan.last_cell;
    tag_in.eor      = in_chan.last_cell && cell_end;
    tag_in.vidx     = p_ext[VIDX_W-1:0];
  end

  always_comb begin
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (cell_end) begin
        pos_nxt = '0;
        if (in_chan.last_cell)     seen_nxt = 2'd0;
        else if (seen_r != 2'd2)   seen_nxt = seen_r + 2'd1;
      end else begin
        pos_nxt = p + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= CFG_W'(1);
      pos_r       <= '0;
      seen_r      <= 2'd0;
    end else begin
      if (cfg_we) var_count_r <= cfg_data;
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign rd_bus[MAX_VARS] = '0;

  for (genvar i = 0; i < MAX_VARS; i++) begin : g_cell
    mmsfr_cell #(
      .DATA_WIDTH (DW),
      .POS_W      (POS_W),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .addr    (p),
      .we      (accept),
      .wr_data (in_chan.cell_value),
      .rd_in   (rd_bus[i+1]),
      .rd_out  (rd_bus[i])
    );
  end

  // flow control: a stage moves when the one after it is empty or moving
  assign o_adv  = (!o_a_r && !o_b_r) || (out_chan.ready && (o_a_r ^ o_b_r));
  assign s4_go  = !s4_v_r || o_adv;
  assign s3_go  = !s3_v_r || s4_go;
  assign s2_go  = !s2_v_r || s3_go;
  assign s1_go  = !s1_v_r || s2_go;
  assign in_chan.ready = s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      o_a_r  <= 1'b0;
      o_b_r  <= 1'b0;
    end else begin
      if (s1_go) s1_v_r <= accept && (tag_in.emit || tag_in.last);
      if (s2_go) s2_v_r <= s1_v_r;
      if (s3_go) s3_v_r <= s2_v_r;
      if (s4_go) s4_v_r <= s3_v_r;
      if (o_adv) begin
        o_a_r <= s4_v_r && s4_tag_r.emit;
        o_b_r <= s4_v_r && s4_tag_r.last;
      end else if (out_chan.ready && o_a_r) begin
        o_a_r <= 1'b0;
      end
    end
  end

  // stage 3: magnitudes and minimum
  always_comb begin
    al = s2_dl_r[DW] ? -s2_dl_r : s2_dl_r;
    ar = s2_dr_r[DW] ? -s2_dr_r : s2_dr_r;
  end

  // stage 4: signed, saturated slope
  always_comb begin
    if (s3_zero_r)     slope_c = '0;
    else if (s3_neg_r) slope_c = (s3_mag_r > HALF_RANGE) ? DMIN : -s3_mag_r[DW-1:0];
    else               slope_c = (s3_mag_r > {1'b0, DMAX}) ? DMAX : s3_mag_r[DW-1:0];
  end

  assign half_c = s4_slope_r >>> 1;

  always_ff @(posedge clk) begin
    if (s1_go && accept) begin
      s1_prev_r <= rd_bus[0][2*DW-1:DW];
      s1_old_r  <= rd_bus[0][DW-1:0];
      s1_val_r  <= in_chan.cell_value;
      s1_tag_r  <= tag_in;
    end
    if (s2_go) begin
      s2_dl_r   <= (DW+1)'(s1_prev_r) - (DW+1)'(s1_old_r);
      s2_dr_r   <= (DW+1)'(s1_val_r) - (DW+1)'(s1_prev_r);
      s2_prev_r <= s1_prev_r;
      s2_val_r  <= s1_val_r;
      s2_tag_r  <= s1_tag_r;
    end
    if (s3_go) begin
      s3_mag_r  <= (al < ar) ? al : ar;
      s3_neg_r  <= s2_dl_r[DW];
      s3_zero_r <= !s2_tag_r.slope_on || (s2_dl_r == '0) || (s2_dr_r == '0) ||
                   (s2_dl_r[DW] != s2_dr_r[DW]);
      s3_prev_r <= s2_prev_r;
      s3_val_r  <= s2_val_r;
      s3_tag_r  <= s2_tag_r;
    end
    if (s4_go) begin
      s4_slope_r <= slope_c;
      s4_prev_r  <= s3_prev_r;
      s4_val_r   <= s3_val_r;
      s4_tag_r   <= s3_tag_r;
    end
    if (o_adv) begin
      o_slope_r <= s4_slope_r;
      o_lf_r    <= sat_w((DW+1)'(s4_prev_r) - (DW+1)'(half_c));
      o_rf_r    <= sat_w((DW+1)'(s4_prev_r) + (DW+1)'(half_c));
      o_val_r   <= s4_val_r;
      o_vidx_r  <= s4_tag_r.vidx;
      o_eor_r   <= s4_tag_r.eor;
    end
  end

  // first pending result is the lagging cell, second the final-cell flush
  assign out_chan.valid      = o_a_r || o_b_r;
  assign out_chan.slope      = o_a_r ? o_slope_r : '0;
  assign out_chan.left_face  = o_a_r ? o_lf_r : o_val_r;
  assign out_chan.right_face = o_a_r ? o_rf_r : o_val_r;
  assign out_chan.var_index  = o_vidx_r;
  assign out_chan.end_of_row = o_a_r ? 1'b0 : o_eor_r;

endmodule

>>> design/mmsfr_checker.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on mmsfr_pkg and minmod_slope_face_reconstruction_macros.svh.
`include "minmod_slope_face_reconstruction_macros.svh"

module mmsfr_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [DATA_WIDTH-1:0]  out_slope,
  input logic signed [DATA_WIDTH-1:0]  out_left_face,
  input logic signed [DATA_WIDTH-1:0]  out_right_face,
  input logic [mmsfr_pkg::VIDX_W-1:0]  out_var_index,
  input logic                          out_end_of_row
);
  import mmsfr_pkg::*;

  `MMSFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MMSFR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_slope) && $stable(out_left_face) && $stable(out_right_face) && $stable(out_var_index) && $stable(out_end_of_row), "result changed while stalled")
  `MMSFR_ASSERT_NOW(a_eor_flat, out_valid && out_end_of_row, out_slope == '0, "row end with non-zero slope")
  `MMSFR_ASSERT_NOW(a_flat_faces, out_valid && (out_slope == '0), out_left_face == out_right_face, "faces differ at zero slope")

endmodule

bind minmod_slope_face_reconstruction mmsfr_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_mmsfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_slope      (out_chan.slope),
  .out_left_face  (out_chan.left_face),
  .out_right_face (out_chan.right_face),
  .out_var_index  (out_chan.var_index),
  .out_end_of_row (out_chan.end_of_row)
);
